// File: hw/rtl/metadata_record_scanner_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the metadata record scanner
// Concurrent checks that are compiled only in simulation.
// ----------------------------------------------------------------------------
`ifndef METADATA_RECORD_SCANNER_TOP_MACROS_SVH
`define METADATA_RECORD_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define MRS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// When the trigger holds, the consequence must hold in the same cycle.
`define MRS_ASSERT_IMP(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);
`else
`define MRS_ASSERT(label, cond, msg)
`define MRS_ASSERT_IMP(label, trig, cons, msg)
`endif

`endif

// File: hw/rtl/mrs_pkg.sv
// ----------------------------------------------------------------------------
// Metadata record scanner package
// Shared constants, codes, types and helper functions.
// ----------------------------------------------------------------------------
package mrs_pkg;

    // Key table size and the widths that follow from it.
    localparam int MaxRecords = 32;
    localparam int TblIdxW    = (MaxRecords > 1) ? $clog2(MaxRecords) : 1;
    localparam int TblCntW    = $clog2(MaxRecords + 1);

    // Field widths.
    localparam int AvailW  = 31;
    localparam int ByteW   = 8;
    localparam int KeyW    = 32;
    localparam int OffW    = 31;
    localparam int StatusW = 4;
    localparam int CountW  = 6;

    // Queue between the front and the back.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // Format constants.
    localparam int          IdLastSystem   = 31;
    localparam int          IdFirstCustom  = 8192;
    localparam int          TypeLast       = 7;
    localparam logic [31:0] MetaMarker     = 32'h4d45_5441;
    localparam int          WordBytes      = 4;
    localparam int          HeaderBytes    = 8;
    localparam int          RecHeaderBytes = 12;

    // Result status codes.
    localparam logic [StatusW-1:0] StOk        = 4'd0;
    localparam logic [StatusW-1:0] StShort     = 4'd1;
    localparam logic [StatusW-1:0] StBadSize   = 4'd2;
    localparam logic [StatusW-1:0] StNoMarker  = 4'd3;
    localparam logic [StatusW-1:0] StShortRec  = 4'd4;
    localparam logic [StatusW-1:0] StBadId     = 4'd5;
    localparam logic [StatusW-1:0] StDuplicate = 4'd6;
    localparam logic [StatusW-1:0] StBadType   = 4'd7;
    localparam logic [StatusW-1:0] StRanOut    = 4'd8;
    localparam logic [StatusW-1:0] StTableFull = 4'd9;
    localparam logic [StatusW-1:0] StBadQuery  = 4'd10;

    // Reply kinds.
    localparam logic KindParse = 1'b0;
    localparam logic KindQuery = 1'b1;

    typedef enum logic [1:0] {
        CmdBegin  = 2'd0,
        CmdData   = 2'd1,
        CmdQuery  = 2'd2,
        CmdUnused = 2'd3
    } t_cmd;

    typedef enum logic [6:0] {
        PhIdle  = 7'b000_0001,
        PhHSize = 7'b000_0010,
        PhHMark = 7'b000_0100,
        PhRSize = 7'b000_1000,
        PhRId   = 7'b001_0000,
        PhRType = 7'b010_0000,
        PhSkip  = 7'b100_0000
    } t_phase;

    // Classified item as it sits in the queue.
    typedef struct packed {
        t_cmd            cmd;
        logic [KeyW-1:0] payload;
    } t_work;

    typedef struct packed {
        logic [QueuePtrW:0] fill;
        logic               empty;
    } t_queue_stat;

    typedef struct packed {
        logic            clr;
        logic            wr;
        logic [KeyW-1:0] wr_key;
        logic [OffW-1:0] wr_off;
    } t_tbl_req;

    typedef struct packed {
        logic               hit;
        logic [OffW-1:0]    hit_off;
        logic [TblCntW-1:0] used;
        logic               full;
    } t_tbl_rsp;

    typedef struct packed {
        logic               kind;
        logic [StatusW-1:0] status;
        logic               found;
        logic [OffW-1:0]    type_offset;
        logic [CountW-1:0]  record_count;
    } t_reply;

    // A valid id is positive and either a system id or a custom id.
    function automatic logic id_ok(input logic [31:0] w);
        logic is_sys;
        logic is_custom;
        is_sys    = (w <= 32'(IdLastSystem));
        is_custom = (w >= 32'(IdFirstCustom));
        return !w[31] && (w != 32'd0) && (is_sys || is_custom);
    endfunction

endpackage

// File: hw/rtl/mrs_front.sv
// ----------------------------------------------------------------------------
// Metadata record scanner front end
// Accepts items, classifies them by command and queues them for the back end.
// ----------------------------------------------------------------------------
module mrs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_in_cmd,
    input  logic [mrs_pkg::AvailW-1:0]   i_in_avail,
    input  logic [mrs_pkg::ByteW-1:0]    i_in_byte,
    input  logic [mrs_pkg::KeyW-1:0]     i_in_key,
    output logic                         o_work_valid,
    output mrs_pkg::t_work               o_work,
    input  logic                         i_work_ready,
    output mrs_pkg::t_queue_stat         o_stat
);
    import mrs_pkg::*;

    t_work                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_fill;

    t_cmd  cmd;
    t_work item;
    logic  push;
    logic  pop;

    assign cmd = t_cmd'(i_in_cmd);

    // Only the field that the command uses is kept; unused codes are dropped.
    always_comb begin
        item.cmd     = cmd;
        item.payload = '0;
        unique case (cmd)
            CmdBegin: item.payload = KeyW'(i_in_avail);
            CmdData:  item.payload = KeyW'(i_in_byte);
            CmdQuery: item.payload = i_in_key;
            default:  item.payload = '0;
        endcase
    end

    assign o_in_ready   = (r_fill != (QueuePtrW + 1)'(QueueDepth));
    assign push         = i_in_valid && o_in_ready && (cmd != CmdUnused);
    assign o_work_valid = (r_fill != '0);
    assign pop          = o_work_valid && i_work_ready;
    assign o_work       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QueuePtrW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QueuePtrW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (QueuePtrW + 1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (QueuePtrW + 1)'(1);
            end
        end
    end

    assign o_stat.fill  = r_fill;
    assign o_stat.empty = (r_fill == '0);

endmodule

// File: hw/rtl/mrs_table.sv
// ----------------------------------------------------------------------------
// Metadata record scanner key table
// Holds accepted ids with their type word offsets; searched by parallel compare.
// ----------------------------------------------------------------------------
module mrs_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mrs_pkg::t_tbl_req         i_req,
    input  logic [mrs_pkg::KeyW-1:0]  i_lookup_key,
    output mrs_pkg::t_tbl_rsp         o_rsp
);
    import mrs_pkg::*;

    logic [KeyW-1:0]       r_key [MaxRecords];
    logic [OffW-1:0]       r_off [MaxRecords];
    logic [MaxRecords-1:0] r_valid;
    logic [TblCntW-1:0]    r_used;

    logic [MaxRecords-1:0] match;
    logic [OffW-1:0]       hit_off;

    // Entries fill in order, so the next free slot is the fill count.
    always_ff @(posedge i_clk) begin
        if (i_req.wr && !i_req.clr) begin
            r_key[r_used[TblIdxW-1:0]] <= i_req.wr_key;
            r_off[r_used[TblIdxW-1:0]] <= i_req.wr_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_req.wr) begin
            r_valid[r_used[TblIdxW-1:0]] <= 1'b1;
            r_used                       <= r_used + TblCntW'(1);
        end
    end

    // Ids in the table are unique, so at most one entry matches.
    always_comb begin
        hit_off = '0;
        for (int i = 0; i < MaxRecords; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_lookup_key);
            hit_off  = hit_off | (r_off[i] & {OffW{match[i]}});
        end
    end

    assign o_rsp.hit     = |match;
    assign o_rsp.hit_off = hit_off;
    assign o_rsp.used    = r_used;
    assign o_rsp.full    = (r_used >= TblCntW'(MaxRecords));

endmodule

// File: hw/rtl/mrs_back.sv
// ----------------------------------------------------------------------------
// Metadata record scanner back end
// Assembles words, walks the header and records, and registers each reply.
// ----------------------------------------------------------------------------
module mrs_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_work_valid,
    input  mrs_pkg::t_work           i_work,
    output logic                     o_work_ready,
    output mrs_pkg::t_tbl_req        o_tbl_req,
    output logic [mrs_pkg::KeyW-1:0] o_lookup_key,
    input  mrs_pkg::t_tbl_rsp        i_tbl_rsp,
    output logic                     o_rep_valid,
    output mrs_pkg::t_reply          o_rep,
    input  logic                     i_rep_ready
);
    import mrs_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [23:0]         r_asm;
    logic [23:0]         n_asm;
    logic [1:0]          r_slot;
    logic [1:0]          n_slot;
    logic [AvailW-1:0]   r_avail;
    logic [AvailW-1:0]   n_avail;
    logic signed [32:0]  r_blob;
    logic signed [32:0]  n_blob;
    logic [OffW-1:0]     r_rec;
    logic [OffW-1:0]     n_rec;
    logic [OffW-1:0]     r_pos;
    logic [OffW-1:0]     n_pos;
    logic [OffW-1:0]     r_cur;
    logic [OffW-1:0]     n_cur;
    logic [TblCntW-1:0]  r_acc;
    logic [TblCntW-1:0]  n_acc;
    logic                r_rep_valid;
    logic                n_rep_valid;
    t_reply              r_rep;
    t_reply              n_rep;

    logic               step;
    logic [31:0]        word;
    logic signed [32:0] sv;
    logic signed [32:0] hdr_limit;
    logic signed [32:0] blob_after;
    logic               fin;
    logic               fin_clr;
    logic [StatusW-1:0] fin_status;
    logic               qry;
    logic [StatusW-1:0] qry_status;
    logic               qry_found;
    logic [OffW-1:0]    qry_off;

    assign o_work_ready = !r_rep_valid || i_rep_ready;
    assign step         = i_work_valid && o_work_ready;
    assign word         = {i_work.payload[7:0], r_asm};
    assign sv           = $signed({word[31], word});
    assign hdr_limit    = $signed({2'b00, r_avail}) + $signed(33'(WordBytes));
    assign blob_after   = r_blob - $signed({2'b00, r_cur});
    assign o_lookup_key = (i_work.cmd == CmdQuery) ? i_work.payload : word;

    always_comb begin
        n_phase     = r_phase;
        n_asm       = r_asm;
        n_slot      = r_slot;
        n_avail     = r_avail;
        n_blob      = r_blob;
        n_rec       = r_rec;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_acc       = r_acc;
        n_rep_valid = r_rep_valid && !i_rep_ready;
        n_rep       = r_rep;
        fin         = 1'b0;
        fin_clr     = 1'b0;
        fin_status  = StOk;
        qry         = 1'b0;
        qry_status  = StOk;
        qry_found   = 1'b0;
        qry_off     = '0;
        o_tbl_req        = '0;
        o_tbl_req.wr_key = word;

        if (step) begin
            unique case (i_work.cmd)
                CmdBegin: begin
                    n_avail = i_work.payload[AvailW-1:0];
                    n_asm   = '0;
                    n_slot  = '0;
                    n_pos   = '0;
                    n_blob  = '0;
                    n_rec   = '0;
                    n_cur   = '0;
                    n_acc   = '0;
                    if (i_work.payload[AvailW-1:0] < AvailW'(HeaderBytes)) begin
                        fin        = 1'b1;
                        fin_status = StShort;
                    end else begin
                        n_phase = PhHSize;
                    end
                end
                CmdData: begin
                    if (r_phase != PhIdle) begin
                        n_pos = r_pos + OffW'(1);
                        if (r_phase == PhSkip) begin
                            n_rec = r_rec - OffW'(1);
                            if (r_rec == OffW'(1)) begin
                                n_phase = PhRSize;
                            end
                        end else if (r_slot != 2'd3) begin
                            case (r_slot)
                                2'd0:    n_asm[7:0]   = i_work.payload[7:0];
                                2'd1:    n_asm[15:8]  = i_work.payload[7:0];
                                default: n_asm[23:16] = i_work.payload[7:0];
                            endcase
                            n_slot = r_slot + 2'd1;
                        end else begin
                            n_asm  = '0;
                            n_slot = '0;
                            unique case (r_phase)
                                PhHSize: begin
                                    if (hdr_limit < sv || sv < $signed(33'(HeaderBytes))) begin
                                        fin        = 1'b1;
                                        fin_status = StBadSize;
                                    end else begin
                                        n_blob  = sv - $signed(33'(HeaderBytes));
                                        n_phase = PhHMark;
                                    end
                                end
                                PhHMark: begin
                                    if (word != MetaMarker) begin
                                        fin        = 1'b1;
                                        fin_status = StNoMarker;
                                    end else begin
                                        o_tbl_req.clr = 1'b1;
                                        if (r_blob > $signed(33'(RecHeaderBytes))) begin
                                            n_phase = PhRSize;
                                        end else if (r_blob == '0) begin
                                            fin        = 1'b1;
                                            fin_status = StOk;
                                        end else begin
                                            fin        = 1'b1;
                                            fin_clr    = 1'b1;
                                            fin_status = StRanOut;
                                        end
                                    end
                                end
                                PhRSize: begin
                                    if (sv <= $signed(33'(RecHeaderBytes))) begin
                                        fin        = 1'b1;
                                        fin_clr    = 1'b1;
                                        fin_status = StShortRec;
                                    end else begin
                                        n_cur   = word[OffW-1:0];
                                        n_phase = PhRId;
                                    end
                                end
                                PhRId: begin
                                    fin_clr = 1'b1;
                                    if (!id_ok(word)) begin
                                        fin        = 1'b1;
                                        fin_status = StBadId;
                                    end else if (i_tbl_rsp.hit) begin
                                        fin        = 1'b1;
                                        fin_status = StDuplicate;
                                    end else if (i_tbl_rsp.full) begin
                                        fin        = 1'b1;
                                        fin_status = StTableFull;
                                    end else begin
                                        // The type word starts right after this id.
                                        o_tbl_req.wr     = 1'b1;
                                        o_tbl_req.wr_off = n_pos;
                                        n_phase          = PhRType;
                                    end
                                end
                                PhRType: begin
                                    fin_clr = 1'b1;
                                    if (sv <= 33'sd0 || sv > $signed(33'(TypeLast))) begin
                                        fin        = 1'b1;
                                        fin_status = StBadType;
                                    end else begin
                                        n_blob = blob_after;
                                        n_acc  = r_acc + TblCntW'(1);
                                        if (blob_after > $signed(33'(RecHeaderBytes))) begin
                                            n_rec   = r_cur - OffW'(RecHeaderBytes);
                                            n_phase = PhSkip;
                                        end else if (blob_after == '0) begin
                                            fin        = 1'b1;
                                            fin_clr    = 1'b0;
                                            fin_status = StOk;
                                        end else begin
                                            fin        = 1'b1;
                                            fin_status = StRanOut;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                CmdQuery: begin
                    qry = 1'b1;
                    if (!id_ok(i_work.payload)) begin
                        qry_status = StBadQuery;
                    end else begin
                        qry_found = i_tbl_rsp.hit;
                        qry_off   = i_tbl_rsp.hit ? i_tbl_rsp.hit_off : '0;
                    end
                end
                default: ;
            endcase
        end

        if (fin) begin
            n_phase            = PhIdle;
            n_asm              = '0;
            n_slot             = '0;
            o_tbl_req.clr      = o_tbl_req.clr || fin_clr;
            n_rep_valid        = 1'b1;
            n_rep.kind         = KindParse;
            n_rep.status       = fin_status;
            n_rep.found        = 1'b0;
            n_rep.type_offset  = '0;
            n_rep.record_count = CountW'(n_acc);
        end else if (qry) begin
            n_rep_valid        = 1'b1;
            n_rep.kind         = KindQuery;
            n_rep.status       = qry_status;
            n_rep.found        = qry_found;
            n_rep.type_offset  = qry_off;
            n_rep.record_count = CountW'(i_tbl_rsp.used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhIdle;
            r_asm       <= '0;
            r_slot      <= '0;
            r_avail     <= '0;
            r_blob      <= '0;
            r_rec       <= '0;
            r_pos       <= '0;
            r_cur       <= '0;
            r_acc       <= '0;
            r_rep_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_asm       <= n_asm;
            r_slot      <= n_slot;
            r_avail     <= n_avail;
            r_blob      <= n_blob;
            r_rec       <= n_rec;
            r_pos       <= n_pos;
            r_cur       <= n_cur;
            r_acc       <= n_acc;
            r_rep_valid <= n_rep_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep <= n_rep;
    end

    assign o_rep_valid = r_rep_valid;
    assign o_rep       = r_rep;

endmodule

// File: hw/rtl/metadata_record_scanner_top.sv
// Path: an accepted item is written into the queue; the back end takes it from the queue
// head, and its result is registered in the reply register that drives the master side.
// Items already queued ahead are handled first. Throughput: one item per cycle unless a
// waiting reply stalls the back end; the back end finishes each item in a single step.
// The four-entry queue lets the input side keep accepting while a reply waits.
// Reset: i_rst_n is synchronous and active low; it idles the scanner, empties the queue
// and marks every key table entry invalid. Table contents are not cleared.
// ----------------------------------------------------------------------------
// Metadata record scanner
// Validates a metadata blob byte by byte and answers presence queries on ids.
// ----------------------------------------------------------------------------
`include "metadata_record_scanner_top_macros.svh"

module metadata_record_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from the lowest up: avail_bytes[30:0], data_byte[38:31],
    // query_key[70:39], zero fill[71].
    input  logic [71:0] s_axis_tdata,
    // Bits from the lowest up: command[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from the lowest up: status[3:0], found[4], type_offset[35:5],
    // record_count[41:36], zero fill[47:42].
    output logic [47:0] m_axis_tdata,
    // Bits from the lowest up: reply_kind[0].
    output logic [0:0]  m_axis_tuser
);
    import mrs_pkg::*;

    // The front end classifies each item and drops the unused command code.
    // Data bytes that arrive while no scan runs are still queued, since only the
    // back end knows the scan phase.
    logic        work_valid;
    logic        work_ready;
    t_work       work;
    t_queue_stat q_stat;

    mrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_cmd     (s_axis_tuser),
        .i_in_avail   (s_axis_tdata[30:0]),
        .i_in_byte    (s_axis_tdata[38:31]),
        .i_in_key     (s_axis_tdata[70:39]),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_work_ready (work_ready),
        .o_stat       (q_stat)
    );

    // The key table compares the lookup key against every entry at once. The
    // back end uses it both for duplicate checks during a scan and for queries.
    t_tbl_req        tbl_req;
    t_tbl_rsp        tbl_rsp;
    logic [KeyW-1:0] lookup_key;

    mrs_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (tbl_req),
        .i_lookup_key (lookup_key),
        .o_rsp        (tbl_rsp)
    );

    // The back end walks the header and records and owns the reply register.
    logic   rep_valid;
    t_reply rep;

    mrs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_ready (work_ready),
        .o_tbl_req    (tbl_req),
        .o_lookup_key (lookup_key),
        .i_tbl_rsp    (tbl_rsp),
        .o_rep_valid  (rep_valid),
        .o_rep        (rep),
        .i_rep_ready  (m_axis_tready)
    );

    assign m_axis_tvalid   = rep_valid;
    assign m_axis_tuser[0] = rep.kind;
    assign m_axis_tdata    = {6'b0, rep.record_count, rep.type_offset, rep.found, rep.status};

    // The table never holds more entries than it has room for.
    `MRS_ASSERT(a_tbl_bound, tbl_rsp.used <= TblCntW'(MaxRecords), "key table overfilled")
    // The queue fill count stays within its depth.
    `MRS_ASSERT(a_queue_bound, q_stat.fill <= (QueuePtrW + 1)'(QueueDepth), "queue overfilled")
    // A parse result never reports a found key or an offset.
    `MRS_ASSERT_IMP(a_parse_clean, rep_valid && rep.kind == KindParse, !rep.found && rep.type_offset == '0, "parse reply carries query data")
    // A rejected query never reports a hit.
    `MRS_ASSERT_IMP(a_bad_query, rep_valid && rep.status == StBadQuery, !rep.found && rep.kind == KindQuery, "bad query reported a hit")

endmodule
